/* hdl/lcgs_pkg.sv */
// Shared types, codes and jump-ahead constants for the LTE CRS Gold sequence generator.
package lcgs_pkg;

  localparam int LFSR_W     = 31;
  localparam int ADVANCE_NC = 1600;
  localparam int CELL_ID_W  = 9;
  localparam int SLOT_W     = 5;
  localparam int SYMBOL_W   = 3;
  localparam int SAMPLE_W   = 16;

  localparam logic signed [SAMPLE_W-1:0] AMP_POS = 16'sd23169;
  localparam logic signed [SAMPLE_W-1:0] AMP_NEG = -16'sd23169;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_NEXT  = 1'b1
  } action_t;

  typedef enum logic {
    REG_CELL_ID   = 1'b0,
    REG_NORMAL_CP = 1'b1
  } reg_index_t;

  typedef struct packed {
    action_t               action;
    logic [SLOT_W-1:0]     slot;
    logic [SYMBOL_W-1:0]   symbol;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ref_real;
    logic signed [SAMPLE_W-1:0] ref_imag;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic shift;
  } chain_ctrl_t;

  typedef logic [LFSR_W-1:0][LFSR_W-1:0] jump_matrix_t;

  function automatic logic [LFSR_W-1:0] step_x1(input logic [LFSR_W-1:0] r);
    logic fb;
    fb = r[0] ^ r[3];
    return {fb, r[LFSR_W-1:1]};
  endfunction

  function automatic logic [LFSR_W-1:0] step_x2(input logic [LFSR_W-1:0] r);
    logic fb;
    fb = r[0] ^ r[1] ^ r[2] ^ r[3];
    return {fb, r[LFSR_W-1:1]};
  endfunction

  function automatic logic [LFSR_W-1:0] jump_x1_start();
    logic [LFSR_W-1:0] r;
    r = {{(LFSR_W-1){1'b0}}, 1'b1};
    for (int n = 0; n < ADVANCE_NC; n++) begin
      r = step_x1(r);
    end
    return r;
  endfunction

  // column i: state reached from a single one in bit i
  function automatic jump_matrix_t jump_x2_matrix();
    jump_matrix_t      m;
    logic [LFSR_W-1:0] r;
    for (int i = 0; i < LFSR_W; i++) begin
      r = '0;
      r[i] = 1'b1;
      for (int n = 0; n < ADVANCE_NC; n++) begin
        r = step_x2(r);
      end
      m[i] = r;
    end
    return m;
  endfunction

  localparam logic [LFSR_W-1:0] X1_START = jump_x1_start();
  localparam jump_matrix_t      X2_JUMP  = jump_x2_matrix();

endpackage

/* hdl/lcgs_cell.sv */
// One chain cell: a single bit of each Gold generator register.
module lcgs_cell
  import lcgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  chain_ctrl_t ctrl,
  input  logic        ld_x1,
  input  logic        ld_x2,
  input  logic        nb_x1,
  input  logic        nb_x2,
  output logic        x1_r,
  output logic        x2_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= 1'b0;
      x2_r <= 1'b0;
    end else if (ctrl.load) begin
      x1_r <= ld_x1;
      x2_r <= ld_x2;
    end else if (ctrl.shift) begin
      x1_r <= nb_x1;
      x2_r <= nb_x2;
    end
  end

endmodule

/* hdl/lcgs_chain.sv */
// Row of generator cells advancing two sequence positions per shift, with jump-ahead load.
module lcgs_chain
  import lcgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  chain_ctrl_t       ctrl,
  input  logic [LFSR_W-1:0] cinit,
  output logic [LFSR_W-1:0] x1_q,
  output logic [1:0]        seq_bits
);

  logic [LFSR_W-1:0] x2_q;
  logic [LFSR_W-1:0] ld_x2;
  logic [LFSR_W-1:0] nb_x1;
  logic [LFSR_W-1:0] nb_x2;

  always_comb begin
    ld_x2 = '0;
    for (int i = 0; i < LFSR_W; i++) begin
      if (cinit[i]) begin
        ld_x2 = ld_x2 ^ X2_JUMP[i];
      end
    end
  end

  // x(n+31) and x(n+32) close the two-step shift
  always_comb begin
    nb_x1 = {x1_q[4] ^ x1_q[1], x1_q[3] ^ x1_q[0], x1_q[LFSR_W-1:2]};
    nb_x2 = {x2_q[4] ^ x2_q[3] ^ x2_q[2] ^ x2_q[1],
             x2_q[3] ^ x2_q[2] ^ x2_q[1] ^ x2_q[0],
             x2_q[LFSR_W-1:2]};
  end

  for (genvar k = 0; k < LFSR_W; k++) begin : g_cell
    lcgs_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .ld_x1 (X1_START[k]),
      .ld_x2 (ld_x2[k]),
      .nb_x1 (nb_x1[k]),
      .nb_x2 (nb_x2[k]),
      .x1_r  (x1_q[k]),
      .x2_r  (x2_q[k])
    );
  end

  assign seq_bits = x1_q[1:0] ^ x2_q[1:0];

endmodule

/* hdl/lte_crs_gold_sequence_generator_top.sv */
// Top level of the LTE CRS Gold sequence generator.
// Output path: a next transaction is held in the action register and, once the output is free,
// its symbol is registered into out_data.
// Throughput: one transaction per cycle, start or next, while out_stall holds back no next transaction.
// The 1600-step advance is a fixed jump matrix applied to c_init in the load path of the cell row.
// Reset: both generators clear to zero, cell_id to 0, normal_cp to 1; no transaction in flight.
module lte_crs_gold_sequence_generator_top
  import lcgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  reg_index_t           cfg_index,
  input  logic [CELL_ID_W-1:0] cfg_data
);

  logic [CELL_ID_W-1:0] cell_id_r;
  logic                 normal_cp_r;

  logic                 a_valid_r;
  logic                 a_valid_nxt;
  action_t              a_action_r;
  logic [LFSR_W-1:0]    a_cinit_r;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  out_item_t            out_data_r;

  logic [7:0]           slot_p1;
  logic [7:0]           sym_term;
  logic [9:0]           cid_odd;
  logic [17:0]          prod;
  logic [LFSR_W-1:0]    cinit;

  logic                 in_accept;
  logic                 out_free;
  logic                 a_fire;
  logic                 fire_start;
  logic                 fire_next;
  chain_ctrl_t          ctrl;
  logic [LFSR_W-1:0]    x1_q;
  logic [1:0]           seq_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_id_r   <= '0;
      normal_cp_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELL_ID:   cell_id_r   <= cfg_data;
        REG_NORMAL_CP: normal_cp_r <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    slot_p1  = {3'b0, in_data.slot} + 8'd1;
    sym_term = 8'(slot_p1 * 8'd7) + {5'b0, in_data.symbol} + 8'd1;
    cid_odd  = {cell_id_r, 1'b1};
    prod     = {10'b0, sym_term} * {8'b0, cid_odd};
    cinit    = {3'b0, prod, 10'b0} + {21'b0, cell_id_r, normal_cp_r};
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign a_fire     = a_valid_r && (a_action_r == ACT_START || out_free);
  assign fire_start = a_fire && (a_action_r == ACT_START);
  assign fire_next  = a_fire && (a_action_r == ACT_NEXT);
  assign in_stall   = a_valid_r && !a_fire;
  assign in_accept  = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_accept) begin
      a_valid_nxt = 1'b1;
    end else if (a_fire) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = fire_next || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_action_r <= in_data.action;
      a_cinit_r  <= cinit;
    end
    if (fire_next) begin
      out_data_r.ref_real <= seq_bits[0] ? AMP_NEG : AMP_POS;
      out_data_r.ref_imag <= seq_bits[1] ? AMP_POS : AMP_NEG;
    end
  end

  assign ctrl.load  = fire_start;
  assign ctrl.shift = fire_next;

  lcgs_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cinit    (a_cinit_r),
    .x1_q     (x1_q),
    .seq_bits (seq_bits)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_next_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire_next |=> out_valid_r)
    else $error("next transaction produced no result");

  a_start_loads_x1: assert property (@(posedge clk) disable iff (!rst_n)
    fire_start |=> (x1_q == X1_START))
    else $error("first generator not at jump-ahead state after start");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && a_action_r == ACT_NEXT && out_valid_r))
    else $error("input stalled without a blocked next transaction");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !fire_next) |=> $stable(out_data_r))
    else $error("waiting result changed");

endmodule
